/* rtl/core/dllm_pkg.sv */
// Shared types and command codes for the doubly linked list manager.
package dllm_pkg;

  localparam int NODE_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [1:0] CMD_INS_FRONT = 2'd0;
  localparam logic [1:0] CMD_INS_BACK  = 2'd1;
  localparam logic [1:0] CMD_REM_FRONT = 2'd2;
  localparam logic [1:0] CMD_UNLINK    = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] node_index;
  } dllm_request_t;

  typedef struct packed {
    logic [NODE_W-1:0]  out_node;
    logic               out_valid;
    logic [COUNT_W-1:0] list_count;
  } dllm_result_t;

endpackage

/* rtl/core/dllm_ram.sv */
// Generic single-write, single-read RAM with registered read (read-old on collision).
module dllm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/doubly_linked_list_manager.sv */
// Doubly linked list manager over a pool of node slots, links kept in two RAMs.
//
// Usage: drive request (cmd, node_index) and raise start while busy is low;
// the request is taken at that clock edge. Commands: insert at front,
// insert at back, remove front, unlink a given slot.
// Each request yields exactly one result on the result port, shown for one
// cycle with done high; done and the result are registered at the edge that
// ends the update cycle. The receiver cannot hold results off.
// The accept cycle reads the slot's links and writes its own links; the
// update cycle (busy high) writes the neighbor links from the read data and
// updates head, tail and count. The single write port of each link RAM
// splits the work this way, and no new request is accepted while busy is high.
// A new request may be accepted in the cycle its predecessor's result is
// shown.
// Reset: head and tail go to the null marker, count to zero, no result
// pending. Link RAMs are not cleared; a slot's links are written whenever
// it is inserted, so no clearing pass is needed.
module doubly_linked_list_manager
  import dllm_pkg::*;
#(
  parameter int POOL_NODES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dllm_request_t request,
  output logic          done,
  output dllm_result_t  result
);

  localparam int ADDR_W = $clog2(POOL_NODES);
  localparam int LINK_W = $clog2(POOL_NODES + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic               state;
  logic [LINK_W-1:0]  head;
  logic [LINK_W-1:0]  tail;
  logic [LINK_W-1:0]  count;
  logic [LINK_W-1:0]  head_next;
  logic [LINK_W-1:0]  tail_next;
  logic [LINK_W-1:0]  count_next;

  logic [1:0]         cmd_q;
  logic [LINK_W-1:0]  slot_q;
  logic [NODE_W-1:0]  node_q;
  logic               act_q;

  logic               accept;
  logic               head_ok;
  logic               in_pool;
  logic               act;
  logic [LINK_W-1:0]  slot;

  logic               nl_we;
  logic [ADDR_W-1:0]  nl_waddr;
  logic [LINK_W-1:0]  nl_wdata;
  logic [LINK_W-1:0]  nl_rdata;
  logic               pl_we;
  logic [ADDR_W-1:0]  pl_waddr;
  logic [LINK_W-1:0]  pl_wdata;
  logic [LINK_W-1:0]  pl_rdata;
  logic [LINK_W-1:0]  nx;
  logic [LINK_W-1:0]  pv;

  function automatic logic [LINK_W-1:0] clean(input logic [LINK_W-1:0] v);
    return (v < NULL_LINK) ? v : NULL_LINK;
  endfunction

  assign busy    = (state == ST_UPDATE);
  assign accept  = start && !busy;
  assign head_ok = (head != NULL_LINK);
  assign in_pool = ({{(32-NODE_W){1'b0}}, request.node_index} < 32'(POOL_NODES));
  assign act     = (request.cmd == CMD_REM_FRONT) ? head_ok : in_pool;
  assign slot    = (request.cmd == CMD_REM_FRONT) ? head : LINK_W'(request.node_index);

  assign nx = clean(nl_rdata);
  assign pv = clean(pl_rdata);

  // Accept cycle: write the slot's own links; update cycle: patch the neighbors.
  always_comb begin
    nl_we    = 1'b0;
    nl_waddr = slot[ADDR_W-1:0];
    nl_wdata = NULL_LINK;
    pl_we    = 1'b0;
    pl_waddr = slot[ADDR_W-1:0];
    pl_wdata = NULL_LINK;
    if (accept && act) begin
      nl_we = 1'b1;
      pl_we = 1'b1;
      if (request.cmd == CMD_INS_FRONT) begin
        nl_wdata = head;
      end
      if (request.cmd == CMD_INS_BACK) begin
        pl_wdata = tail;
      end
    end else if (busy && act_q) begin
      unique case (cmd_q)
        CMD_INS_FRONT: begin
          pl_we    = head_ok;
          pl_waddr = head[ADDR_W-1:0];
          pl_wdata = slot_q;
        end
        CMD_INS_BACK: begin
          nl_we    = head_ok && (tail != NULL_LINK);
          nl_waddr = tail[ADDR_W-1:0];
          nl_wdata = slot_q;
        end
        CMD_REM_FRONT: begin
          pl_we    = (nx != NULL_LINK);
          pl_waddr = nx[ADDR_W-1:0];
          pl_wdata = NULL_LINK;
        end
        CMD_UNLINK: begin
          // a neighbor equal to the slot itself keeps the null written at accept
          nl_we    = (pv != NULL_LINK) && (pv != slot_q);
          nl_waddr = pv[ADDR_W-1:0];
          nl_wdata = nx;
          pl_we    = (nx != NULL_LINK) && (nx != slot_q);
          pl_waddr = nx[ADDR_W-1:0];
          pl_wdata = pv;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (act_q) begin
      unique case (cmd_q)
        CMD_INS_FRONT: begin
          head_next = slot_q;
          if (!head_ok) begin
            tail_next = slot_q;
          end
          count_next = (count == NULL_LINK) ? count : count + LINK_W'(1);
        end
        CMD_INS_BACK: begin
          tail_next = slot_q;
          if (!head_ok) begin
            head_next = slot_q;
          end
          count_next = (count == NULL_LINK) ? count : count + LINK_W'(1);
        end
        CMD_REM_FRONT: begin
          head_next = nx;
          if (nx == NULL_LINK) begin
            tail_next = NULL_LINK;
          end
          count_next = (count == '0) ? count : count - LINK_W'(1);
        end
        CMD_UNLINK: begin
          if (slot_q == head) begin
            head_next = nx;
          end
          if (slot_q == tail) begin
            tail_next = pv;
          end
          count_next = (count == '0) ? count : count - LINK_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= NULL_LINK;
      tail  <= NULL_LINK;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
          head  <= head_next;
          tail  <= tail_next;
          count <= count_next;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the request while the update cycle runs.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= request.cmd;
      slot_q <= slot;
      act_q  <= act;
      if (request.cmd == CMD_REM_FRONT) begin
        node_q <= head_ok ? NODE_W'(head) : '0;
      end else begin
        node_q <= request.node_index;
      end
    end
    if (busy) begin
      result.out_node   <= node_q;
      result.out_valid  <= act_q;
      result.list_count <= COUNT_W'(count_next);
    end
  end

  dllm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_NODES)
  ) u_next_ram (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .raddr (slot[ADDR_W-1:0]),
    .rdata (nl_rdata)
  );

  dllm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_NODES)
  ) u_prev_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (slot[ADDR_W-1:0]),
    .rdata (pl_rdata)
  );

  a_accept_to_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not enter update cycle");

  a_busy_to_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("update cycle did not produce exactly one result");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding update cycle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count <= NULL_LINK) && (head <= NULL_LINK) && (tail <= NULL_LINK))
    else $error("count or end pointer out of range");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.cmd == CMD_REM_FRONT) && !head_ok)
      |=> ##1 (done && !result.out_valid && (result.out_node == '0)))
    else $error("remove on empty list reported a node");

endmodule
